[rtl/assert_macros.svh]
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, held off while reset is active.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication checked in the cycle after its antecedent.
`define ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

[rtl/dbd_pkg.sv]
package dbd_pkg;

  localparam int unsigned YEAR_MAX    = 9999;
  localparam int unsigned MONTHS      = 12;
  localparam int unsigned DAYS_PER_YR = 365;
  // floor(x / 100) == (x * RECIP_100) >> RECIP_SHIFT for every 14-bit x
  localparam int unsigned RECIP_100   = 5243;
  localparam int unsigned RECIP_SHIFT = 19;
  localparam int unsigned CENTURY     = 100;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_INVALID = 2'd1,
    STATUS_ORDER   = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_LEAP,
    ST_SUM,
    ST_FIN
  } ctrl_state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture input fields
    logic sel;       // 0 start date, 1 end date
    logic do_mul;
    logic do_leap;
    logic do_sum;
    logic out_load;  // write result register
  } dbd_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;  // result register can take a new value this cycle
  } dbd_stat_t;

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  // days in the months before month m, February taken as 28
  function automatic logic [8:0] cum_days(input logic [3:0] m);
    logic [8:0] c;
    case (m)
      4'd1:    c = 9'd0;
      4'd2:    c = 9'd31;
      4'd3:    c = 9'd59;
      4'd4:    c = 9'd90;
      4'd5:    c = 9'd120;
      4'd6:    c = 9'd151;
      4'd7:    c = 9'd181;
      4'd8:    c = 9'd212;
      4'd9:    c = 9'd243;
      4'd10:   c = 9'd273;
      4'd11:   c = 9'd304;
      4'd12:   c = 9'd334;
      default: c = 9'd0;
    endcase
    return c;
  endfunction

endpackage

[rtl/dbd_ctrl.sv]
module dbd_ctrl
  import dbd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  dbd_stat_t stat_i,
  output dbd_cmd_t  cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        sel_q, sel_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      sel_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      sel_q   <= sel_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    sel_d   = sel_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_MUL;
          sel_d   = 1'b0;
        end
      end
      ST_MUL:  state_d = ST_LEAP;
      ST_LEAP: state_d = ST_SUM;
      ST_SUM: begin
        if (sel_q) begin
          state_d = ST_FIN;
        end else begin
          state_d = ST_MUL;
          sel_d   = 1'b1;
        end
      end
      ST_FIN: begin
        if (stat_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    cmd_o.sel  = sel_q;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      ST_MUL:  cmd_o.do_mul  = 1'b1;
      ST_LEAP: cmd_o.do_leap = 1'b1;
      ST_SUM:  cmd_o.do_sum  = 1'b1;
      ST_FIN:  cmd_o.out_load = stat_i.out_free;
      default: in_stall_o = 1'b1;
    endcase
  end

endmodule

[rtl/dbd_datapath.sv]
`include "assert_macros.svh"

module dbd_datapath
  import dbd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  dbd_cmd_t    cmd_i,
  output dbd_stat_t   stat_o,
  input  logic [4:0]  start_day_i,
  input  logic [3:0]  start_month_i,
  input  logic [13:0] start_year_i,
  input  logic [4:0]  end_day_i,
  input  logic [3:0]  end_month_i,
  input  logic [13:0] end_year_i,
  input  logic        count_end_day_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [21:0] day_count_o,
  output logic [1:0]  status_o
);

  // captured request
  logic [4:0]  sd_q, ed_q;
  logic [3:0]  sm_q, em_q;
  logic [13:0] sy_q, ey_q;
  logic        inc_q;

  // per-date working registers
  logic [7:0]  q_q;       // y / 100
  logic [21:0] p365_q;    // (y - 1) * 365
  logic [11:0] yterm_q;   // p/4 - p/100 + p/400
  logic [8:0]  mterm_q;   // days into the year
  logic        dvalid_q;

  logic [21:0] serial_a_q, serial_b_q;
  logic        valid_a_q, valid_b_q;

  logic        out_valid_q;
  logic [21:0] count_q;
  status_e     status_q;

  // selected date
  logic [4:0]  d;
  logic [3:0]  m;
  logic [13:0] y, p;
  assign d = cmd_i.sel ? ed_q : sd_q;
  assign m = cmd_i.sel ? em_q : sm_q;
  assign y = cmd_i.sel ? ey_q : sy_q;
  assign p = y - 14'd1;

  // step 1: reciprocal divide and year multiply
  logic [26:0] prod100;
  logic [21:0] p365;
  assign prod100 = 27'(y) * 27'(RECIP_100);
  assign p365    = 22'(p) * 22'(DAYS_PER_YR);

  // step 2: remainder, leap rule, validity
  logic [13:0] rem100;
  logic        rem_zero, leap;
  logic [7:0]  p100;
  logic [11:0] yterm;
  logic [8:0]  mterm;
  logic        dvalid;
  assign rem100   = y - 14'(14'(q_q) * 14'(CENTURY));
  assign rem_zero = (rem100 == 14'd0);
  assign leap     = (y[1:0] == 2'd0 && !rem_zero) || (rem_zero && q_q[1:0] == 2'd0);
  assign p100     = rem_zero ? q_q - 8'd1 : q_q;
  assign yterm    = 12'(p[13:2]) - 12'(p100) + 12'(p100[7:2]);
  assign mterm    = cum_days(m) + 9'((leap && m > 4'd2) ? 1 : 0) + 9'(d);
  assign dvalid   = (y >= 14'd1) && (y <= 14'(YEAR_MAX)) &&
                    (m >= 4'd1) && (m <= 4'(MONTHS)) &&
                    (d >= 5'd1) && (d <= month_len(m, leap));

  // step 3: serial day number
  logic [21:0] serial;
  assign serial = p365_q + 22'(yterm_q) + 22'(mterm_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sd_q  <= start_day_i;
      sm_q  <= start_month_i;
      sy_q  <= start_year_i;
      ed_q  <= end_day_i;
      em_q  <= end_month_i;
      ey_q  <= end_year_i;
      inc_q <= count_end_day_i;
    end
    if (cmd_i.do_mul) begin
      q_q    <= prod100[26:RECIP_SHIFT];
      p365_q <= p365;
    end
    if (cmd_i.do_leap) begin
      yterm_q  <= yterm;
      mterm_q  <= mterm;
      dvalid_q <= dvalid;
    end
    if (cmd_i.do_sum) begin
      if (cmd_i.sel) begin
        serial_b_q <= serial;
        valid_b_q  <= dvalid_q;
      end else begin
        serial_a_q <= serial;
        valid_a_q  <= dvalid_q;
      end
    end
  end

  // result
  logic [21:0] diff;
  assign diff = serial_b_q - serial_a_q + 22'(inc_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      if (!(valid_a_q && valid_b_q)) begin
        status_q <= STATUS_INVALID;
        count_q  <= '0;
      end else if (serial_a_q > serial_b_q) begin
        status_q <= STATUS_ORDER;
        count_q  <= '0;
      end else begin
        status_q <= STATUS_OK;
        count_q  <= diff;
      end
    end
  end

  assign stat_o.out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o     = out_valid_q;
  assign day_count_o     = count_q;
  assign status_o        = status_q;

  `ASSERT_CLK(a_err_zero, !(out_valid_q && status_q != STATUS_OK) || count_q == 22'd0,
    "error result with nonzero count")
  `ASSERT_NEXT(a_load_valid, cmd_i.out_load, out_valid_q, "result load lost")
  `ASSERT_CLK(a_no_overwrite, !(cmd_i.out_load && out_valid_q && out_stall_i),
    "result overwritten while stalled")

endmodule

[rtl/days_between_dates.sv]
// Channel  Direction  Handshake               Payload
// in       input      in_valid_i / in_stall_o  start_day/month/year, end_day/month/year,
//                                              count_end_day
// out      output     out_valid_o / out_stall_i day_count, status
//
// Each transfer in yields one transfer out, loaded in the controller's final step.
// The controller runs three steps per date (multiply, leap rule, sum) over a
// shared datapath, then forms the result; in_stall_o stays high until it is idle.
// A new item is accepted while an earlier result still waits in the output
// register; a stalled output holds the controller in its final step.
// rst_ni is asynchronous, active low; it clears the controller and out_valid_o.
module days_between_dates
  import dbd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [4:0]  start_day_i,
  input  logic [3:0]  start_month_i,
  input  logic [13:0] start_year_i,
  input  logic [4:0]  end_day_i,
  input  logic [3:0]  end_month_i,
  input  logic [13:0] end_year_i,
  input  logic        count_end_day_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [21:0] day_count_o,
  output logic [1:0]  status_o
);

  // command and status between sequencer and datapath
  dbd_cmd_t  cmd;
  dbd_stat_t stat;

  // sequencer: steps start date, then end date, then loads the result
  dbd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // datapath: serial day numbers by reciprocal divide, leap rule,
  // month table, then compare and difference
  dbd_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .start_day_i     (start_day_i),
    .start_month_i   (start_month_i),
    .start_year_i    (start_year_i),
    .end_day_i       (end_day_i),
    .end_month_i     (end_month_i),
    .end_year_i      (end_year_i),
    .count_end_day_i (count_end_day_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .day_count_o     (day_count_o),
    .status_o        (status_o)
  );

endmodule
